// File: src/hfcr_pkg.sv
// ---------------------------------------------------------------------------
// hfcr_pkg: shared types and constants
// header codes, mode enum and result word type for the command receiver
// ---------------------------------------------------------------------------
`default_nettype none

package hfcr_pkg;

    localparam int PARAM_LEN_DEFAULT = 16;

    localparam logic [7:0] HDR_FIRST  = 8'h56;  // 'V'
    localparam logic [7:0] HDR_SECOND = 8'h4E;  // 'N'
    localparam logic [7:0] HDR_THIRD  = 8'h44;  // 'D'
    localparam logic [7:0] SEL_CMD    = 8'h5F;  // '_'
    localparam logic [7:0] SEL_PARAM  = 8'h23;  // '#'

    localparam logic [1:0] HDR_NONE  = 2'd0;
    localparam logic [1:0] HDR_GOT_V = 2'd1;
    localparam logic [1:0] HDR_GOT_N = 2'd2;
    localparam logic [1:0] HDR_FULL  = 2'd3;

    localparam logic KIND_CMD   = 1'b0;
    localparam logic KIND_PARAM = 1'b1;

    typedef enum logic [1:0] {
        MODE_HUNT  = 2'd0,
        MODE_CMD   = 2'd1,
        MODE_PARAM = 2'd2
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// File: src/hfcr_in_stage.sv
// ---------------------------------------------------------------------------
// hfcr_in_stage: input register
// holds one received byte until the parser takes it
// ---------------------------------------------------------------------------
`default_nettype none

module hfcr_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    output logic [7:0]      o_rx_byte,
    input  wire logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    // refill in the same cycle the held word is taken
    assign o_ready   = !r_valid || i_take;
    assign o_valid   = r_valid;
    assign o_rx_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: src/hfcr_parser.sv
// ---------------------------------------------------------------------------
// hfcr_parser: header hunt and frame state machine
// matches the header, then emits a command byte or a parameter frame
// ---------------------------------------------------------------------------
`default_nettype none

module hfcr_parser #(
    parameter int PARAM_LEN = hfcr_pkg::PARAM_LEN_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_out_ready,
    output logic            o_take,
    output logic            o_res_valid,
    output hfcr_pkg::t_result o_res
);

    localparam logic [6:0] FRAME_LEN = 7'(PARAM_LEN);

    hfcr_pkg::t_mode r_mode, n_mode;
    logic [1:0]      r_hdr, n_hdr;
    logic [5:0]      r_count, n_count;

    logic       produce;
    logic [6:0] next_count;
    logic       fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hfcr_pkg::MODE_HUNT;
            r_hdr   <= hfcr_pkg::HDR_NONE;
            r_count <= 6'd0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_hdr   <= n_hdr;
            r_count <= n_count;
        end
    end

    assign next_count = {1'b0, r_count} + 7'd1;
    assign fin        = next_count >= FRAME_LEN;

    always_comb begin
        n_mode           = hfcr_pkg::MODE_HUNT;
        n_hdr            = r_hdr;
        n_count          = r_count;
        produce          = 1'b0;
        o_res.kind       = hfcr_pkg::KIND_CMD;
        o_res.data_byte  = i_rx_byte;
        o_res.byte_index = 6'd0;
        o_res.last       = 1'b1;
        case (r_mode)
            hfcr_pkg::MODE_CMD: begin
                produce = 1'b1;
                n_mode  = hfcr_pkg::MODE_HUNT;
            end
            hfcr_pkg::MODE_PARAM: begin
                produce          = 1'b1;
                o_res.kind       = hfcr_pkg::KIND_PARAM;
                o_res.byte_index = r_count;
                o_res.last       = fin;
                if (fin) begin
                    n_count = 6'd0;
                    n_mode  = hfcr_pkg::MODE_HUNT;
                end else begin
                    n_count = next_count[5:0];
                    n_mode  = hfcr_pkg::MODE_PARAM;
                end
            end
            default: begin
                // hunting; the unused mode code behaves the same
                case (i_rx_byte)
                    hfcr_pkg::HDR_FIRST: begin
                        n_hdr = hfcr_pkg::HDR_GOT_V;
                    end
                    hfcr_pkg::HDR_SECOND: begin
                        n_hdr = (r_hdr == hfcr_pkg::HDR_GOT_V) ? hfcr_pkg::HDR_GOT_N
                                                                : hfcr_pkg::HDR_NONE;
                    end
                    hfcr_pkg::HDR_THIRD: begin
                        n_hdr = (r_hdr == hfcr_pkg::HDR_GOT_N) ? hfcr_pkg::HDR_FULL
                                                                : hfcr_pkg::HDR_NONE;
                    end
                    hfcr_pkg::SEL_CMD: begin
                        if (r_hdr == hfcr_pkg::HDR_FULL) begin
                            n_mode = hfcr_pkg::MODE_CMD;
                        end
                        n_hdr = hfcr_pkg::HDR_NONE;
                    end
                    hfcr_pkg::SEL_PARAM: begin
                        if (r_hdr == hfcr_pkg::HDR_FULL) begin
                            n_mode = hfcr_pkg::MODE_PARAM;
                        end
                        n_hdr = hfcr_pkg::HDR_NONE;
                    end
                    default: begin
                        n_hdr = hfcr_pkg::HDR_NONE;
                    end
                endcase
            end
        endcase
    end

    // a word with no result never waits on the output side
    assign o_take      = i_valid && (!produce || i_out_ready);
    assign o_res_valid = o_take && produce;

endmodule

`default_nettype wire

// File: src/hfcr_out_stage.sv
// ---------------------------------------------------------------------------
// hfcr_out_stage: result register
// holds one result word until the consumer takes it
// ---------------------------------------------------------------------------
`default_nettype none

module hfcr_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire hfcr_pkg::t_result i_res,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hfcr_pkg::t_result      o_res
);

    logic              r_valid;
    hfcr_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: src/header_framed_command_receiver_unit.sv
// path: an accepted byte is registered in the input stage, then its result word in the output stage
// throughput: one byte per cycle; each register refills in the cycle its word
// moves on, so the input stalls only while an unread result word blocks the parser
// bytes that give no result (header hunt) never wait on the output side
// reset: synchronous active-low i_rst_n clears both stage valids, the mode,
// header progress and frame count; the block takes bytes the cycle after
// ---------------------------------------------------------------------------
// header_framed_command_receiver_unit: top level
// byte-stream receiver that extracts command bytes and parameter frames
// ---------------------------------------------------------------------------
`default_nettype none

module header_framed_command_receiver_unit #(
    parameter int PARAM_LEN = hfcr_pkg::PARAM_LEN_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_kind,
    output logic [7:0]      o_data_byte,
    output logic [5:0]      o_byte_index,
    output logic            o_last
);

    logic              s1_valid;
    logic [7:0]        s1_byte;
    logic              s1_take;
    logic              res_valid;
    hfcr_pkg::t_result res;
    logic              out_can_load;
    hfcr_pkg::t_result out_res;

    hfcr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .o_valid   (s1_valid),
        .o_rx_byte (s1_byte),
        .i_take    (s1_take)
    );

    hfcr_parser #(
        .PARAM_LEN (PARAM_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_rx_byte   (s1_byte),
        .i_out_ready (out_can_load),
        .o_take      (s1_take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hfcr_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (out_can_load),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_kind       = out_res.kind;
    assign o_data_byte  = out_res.data_byte;
    assign o_byte_index = out_res.byte_index;
    assign o_last       = out_res.last;

endmodule

`default_nettype wire

// File: src/hfcr_checker.sv
// ---------------------------------------------------------------------------
// hfcr_checker: port-level checks
// watches the result channel of the command receiver over time
// ---------------------------------------------------------------------------
`default_nettype none

module hfcr_checker #(
    parameter int PARAM_LEN = hfcr_pkg::PARAM_LEN_DEFAULT
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_kind,
    input wire logic [7:0] o_data_byte,
    input wire logic [5:0] o_byte_index,
    input wire logic       o_last
);

    localparam logic [6:0] LAST_IDX = 7'(PARAM_LEN - 1);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_byte) && $stable(o_kind)
                                && $stable(o_byte_index) && $stable(o_last))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == hfcr_pkg::KIND_CMD |-> o_last && o_byte_index == 6'd0)
        else $error("command word not last or nonzero index");

    // last flag goes with the final index of the frame
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == hfcr_pkg::KIND_PARAM
            |-> o_last == ({1'b0, o_byte_index} == LAST_IDX))
        else $error("parameter last flag does not match index");

    // after a non-final parameter word the next word continues the frame
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_kind == hfcr_pkg::KIND_PARAM && !o_last) ##1 o_valid
            |-> o_kind == hfcr_pkg::KIND_PARAM
                && o_byte_index == 6'($past(o_byte_index) + 6'd1))
        else $error("parameter frame index out of sequence");

endmodule

bind header_framed_command_receiver_unit hfcr_checker #(
    .PARAM_LEN (PARAM_LEN)
) u_hfcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_data_byte  (o_data_byte),
    .o_byte_index (o_byte_index),
    .o_last       (o_last)
);

`default_nettype wire
